[rtl/core/fcsu_pkg.sv]
// ----------------------------------------------------------------------------
// Four-channel sound unit package
// Shared widths, constants and the front-to-back word type.
// ----------------------------------------------------------------------------
package fcsu_pkg;

   localparam int TICKS_PER_SAMPLE = 16;
   localparam int TickWidth = $clog2(TICKS_PER_SAMPLE);
   localparam int QueueDepth = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);

   localparam logic [5:0] AddrNr52 = 6'd22;

   // One classified word handed from the front to the back.
   typedef struct packed {
      logic       is_write;
      logic       emit;
      logic [5:0] addr;
      logic [7:0] data;
      logic [7:0] div_value;
   } op_type;

   typedef struct packed {
      logic signed [14:0] left_sample;
      logic signed [14:0] right_sample;
      logic [3:0]         active_channels;
   } result_type;

endpackage

[rtl/core/four_channel_sound_unit_top.sv]
// ----------------------------------------------------------------------------
// Four-channel sound unit
//
// Channel  Direction  Contents
// req      in         tick or register / wave RAM write word
// rsp      out        mixed stereo sample every sixteenth tick
//
// The back end takes a word per cycle; an emitting word waits for a free result slot.
// A four-entry queue parts the front end from the back end; the result
// register holds a sample while the back end keeps working until it must emit.
// Reset is synchronous and clears all sound state.
// ----------------------------------------------------------------------------
module four_channel_sound_unit_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tuser,  // [0] mode
   input  logic [23:0] req_tdata,  // [5:0] reg_addr, [13:6] reg_data, [21:14] div_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // [14:0] left, [29:15] right, [33:30] active
);
   import fcsu_pkg::*;

   logic       op_valid, op_ready;
   op_type     op;
   result_type res;

   fcsu_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_mode(req_tuser[0]), .in_addr(req_tdata[5:0]),
      .in_data(req_tdata[13:6]), .in_div(req_tdata[21:14]),
      .op_valid(op_valid), .op_ready(op_ready), .op(op)
   );

   fcsu_back u_back (
      .clock(clock), .reset(reset),
      .op_valid(op_valid), .op_ready(op_ready), .op(op),
      .res_valid(rsp_tvalid), .res_ready(rsp_tready), .res(res)
   );

   assign rsp_tdata = {6'd0, res.active_channels, res.right_sample, res.left_sample};

endmodule

[rtl/core/fcsu_front.sv]
// ----------------------------------------------------------------------------
// Four-channel sound unit front end
// Accepts words, counts ticks, marks sample ticks and queues operations.
// ----------------------------------------------------------------------------
module fcsu_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  logic            in_mode,
   input  logic [5:0]      in_addr,
   input  logic [7:0]      in_data,
   input  logic [7:0]      in_div,
   output logic            op_valid,
   input  logic            op_ready,
   output fcsu_pkg::op_type op
);
   import fcsu_pkg::*;

   logic [TickWidth-1:0]     tick_ff, tick_in;
   op_type                   queue_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ff, rd_ff;
   logic [QueuePtrWidth:0]   count_ff;
   logic                     push, pop;
   op_type                   word;

   assign in_ready = (count_ff != QueueDepth[QueuePtrWidth:0]);
   assign push = in_valid && in_ready;
   assign op_valid = (count_ff != '0);
   assign pop = op_valid && op_ready;
   assign op = queue_ff[rd_ff];

   always_comb begin
      tick_in = tick_ff;
      if (!in_mode) begin
         tick_in = (tick_ff == TickWidth'(TICKS_PER_SAMPLE - 1)) ? '0 : tick_ff + 1'b1;
      end
      word.is_write = in_mode;
      word.emit = !in_mode && (tick_in == '0);
      word.addr = in_addr;
      word.data = in_data;
      word.div_value = in_div;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            tick_ff <= tick_in;
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         count_ff <= count_ff + (QueuePtrWidth+1)'(push) - (QueuePtrWidth+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ff] <= word;
      end
   end

endmodule

[rtl/core/fcsu_back.sv]
// ----------------------------------------------------------------------------
// Four-channel sound unit back end
// Runs register writes and channel ticks; mixes a sample on marked ticks.
// ----------------------------------------------------------------------------
module fcsu_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 op_valid,
   output logic                 op_ready,
   input  fcsu_pkg::op_type     op,
   output logic                 res_valid,
   input  logic                 res_ready,
   output fcsu_pkg::result_type res
);
   import fcsu_pkg::*;

   logic [7:0]  regs_ff [23];
   logic [7:0]  wave_ff [16];
   logic [3:0]  on_ff, pend_ff;
   logic [2:0]  dac_ff;
   logic [15:0] per_ff [4];
   logic [7:0]  pos_ff [4];
   logic [7:0]  env_ff [3];
   logic [7:0]  sweep_ff, frame_ff, lastdiv_ff;
   logic [14:0] lfsr_ff;
   logic [1:0]  pre_ff;
   logic        res_valid_ff;
   result_type  res_ff;

   logic [7:0]  regs_in [23];
   logic [7:0]  wave_in [16];
   logic [3:0]  on_in, pend_in;
   logic [2:0]  dac_in;
   logic [15:0] per_in [4];
   logic [7:0]  pos_in [4];
   logic [7:0]  env_in [3];
   logic [7:0]  sweep_in, frame_in;
   logic [14:0] lfsr_in;
   logic [1:0]  pre_in;

   logic        fire;
   logic        power;
   logic [10:0] p0, p1, p2, sp;
   logic [11:0] sn;
   logic [10:0] sd;
   logic [15:0] lim;
   logic [19:0] limw;
   logic        fb;
   logic [2:0]  pace, slope;
   logic [3:0]  vol;
   logic [2:0]  epace;
   logic signed [9:0] c [4];
   logic signed [11:0] lsum, rsum;
   logic signed [15:0] lmix, rmix;
   logic [4:0]  ws;
   logic [7:0]  wb;
   logic signed [5:0] wv;
   logic [2:0]  ps;
   logic signed [6:0] pv;
   logic        hi;
   logic [7:0]  lr, ln;
   logic [7:0]  lmask;
   int          er, lreg, creg;

   assign fire = op_valid && op_ready;
   // Only a word that emits a sample has to wait for the result register.
   assign op_ready = !res_valid_ff || res_ready || !op.emit;
   assign res_valid = res_valid_ff;
   assign res = res_ff;
   assign power = regs_ff[22][7];

   always_comb begin
      regs_in = regs_ff; wave_in = wave_ff; on_in = on_ff; pend_in = pend_ff;
      dac_in = dac_ff; per_in = per_ff; pos_in = pos_ff; env_in = env_ff;
      sweep_in = sweep_ff; frame_in = frame_ff; lfsr_in = lfsr_ff; pre_in = pre_ff;
      p0 = '0; p1 = '0; p2 = '0; sp = '0; sn = '0; sd = '0; lim = '0; limw = '0;
      fb = 1'b0; pace = '0; slope = '0; vol = '0; epace = '0;
      lr = '0; ln = '0; lmask = '0; er = 0; lreg = 0; creg = 0;
      if (op.is_write) begin
         if (op.addr >= 6'd32 && op.addr < 6'd48) begin
            wave_in[op.addr[3:0]] = op.data;
         end else if (op.addr == AddrNr52) begin
            if (!op.data[7] && power) begin
               for (int i = 0; i < 22; i++) regs_in[i] = '0;
               on_in = '0; pend_in = '0; dac_in = '0;
            end
            regs_in[22] = {op.data[7], 7'd0};
         end else if (op.addr <= 6'd21 && op.addr != 6'd5 && op.addr != 6'd15 && power) begin
            if (op.addr == 6'd4 || op.addr == 6'd9 || op.addr == 6'd14 || op.addr == 6'd19) begin
               regs_in[op.addr[4:0]] = {1'b0, op.data[6:0]};
               if (op.data[7]) begin
                  pend_in[op.addr == 6'd4 ? 0 : op.addr == 6'd9 ? 1 : op.addr == 6'd14 ? 2 : 3]
                     = 1'b1;
               end
            end else begin
               regs_in[op.addr[4:0]] = op.data;
               if (op.addr == 6'd2 || op.addr == 6'd7 || op.addr == 6'd17) begin
                  if (op.data[7:3] != '0) begin
                     dac_in[op.addr == 6'd2 ? 0 : op.addr == 6'd7 ? 1 : 2] = 1'b1;
                  end else begin
                     dac_in[op.addr == 6'd2 ? 0 : op.addr == 6'd7 ? 1 : 2] = 1'b0;
                     on_in[op.addr == 6'd2 ? 0 : op.addr == 6'd7 ? 1 : 3] = 1'b0;
                  end
               end
               if (op.addr == 6'd10 && !op.data[7]) on_in[2] = 1'b0;
            end
         end
      end else begin
         pre_in = pre_ff + 1'b1;
         if (power) begin
            p0 = {regs_ff[4][2:0], regs_ff[3]};
            p1 = {regs_ff[9][2:0], regs_ff[8]};
            p2 = {regs_ff[14][2:0], regs_ff[13]};
            if (pend_in[0] && dac_in[0]) begin
               pend_in[0] = 1'b0; on_in[0] = 1'b1; per_in[0] = {5'd0, p0};
            end
            if (pend_in[1] && dac_in[1]) begin
               pend_in[1] = 1'b0; on_in[1] = 1'b1; per_in[1] = {5'd0, p1};
            end
            if (pend_in[2] && regs_ff[10][7]) begin
               pend_in[2] = 1'b0; on_in[2] = 1'b1; pos_in[2] = '0; per_in[2] = {5'd0, p2};
            end
            if (pend_in[3] && dac_in[2]) begin
               pend_in[3] = 1'b0; on_in[3] = 1'b1; pos_in[3] = '0; per_in[3] = '0;
               lfsr_in = 15'h7fff;
            end
            if (on_in[0]) begin
               per_in[0] = per_in[0] + 16'd1;
               if (per_in[0] >= 16'd2048) begin
                  per_in[0] = {5'd0, p0}; pos_in[0] = pos_in[0] + 8'd1;
               end
            end
            if (on_in[1]) begin
               per_in[1] = per_in[1] + 16'd1;
               if (per_in[1] >= 16'd2048) begin
                  per_in[1] = {5'd0, p1}; pos_in[1] = pos_in[1] + 8'd1;
               end
            end
            if (on_in[2]) begin
               per_in[2] = per_in[2] + 16'd2;
               if (per_in[2] >= 16'd2048) begin
                  per_in[2] = per_in[2] - 16'd2048 + {5'd0, p2};
                  pos_in[2] = {3'd0, pos_in[2][4:0] + 5'd1};
               end
            end
            if (on_in[3] && pre_ff == 2'd3) begin
               limw = 20'd1 << regs_ff[18][7:4];
               if (regs_ff[18][2:0] != '0) limw = limw * {17'd0, regs_ff[18][2:0]};
               else limw = limw >> 1;
               lim = limw[15:0];
               per_in[3] = per_in[3] + 16'd1;
               if (per_in[3] >= lim) begin
                  fb = lfsr_in[0] ^ lfsr_in[1];
                  per_in[3] = '0;
                  lfsr_in = {fb, lfsr_in[14:1]};
                  if (regs_ff[18][3]) lfsr_in[6] = fb;
                  pos_in[3] = {7'd0, ~lfsr_in[0]};
               end
            end
            if (lastdiv_ff[4] && !op.div_value[4]) begin
               frame_in = frame_ff + 8'd1;
               if (!frame_in[0]) begin
                  for (int k = 0; k < 4; k++) begin
                     lreg = (k == 0) ? 1 : (k == 1) ? 6 : (k == 2) ? 11 : 16;
                     creg = lreg + 3;
                     lmask = (k == 2) ? 8'hff : 8'h3f;
                     if (regs_in[creg][6] && on_in[k]) begin
                        lr = regs_in[lreg];
                        ln = (lr + 8'd1) & lmask;
                        regs_in[lreg] = (lr & ~lmask) | ln;
                        if (ln == '0) on_in[k] = 1'b0;
                     end
                  end
               end
               if (frame_in[1:0] == 2'd0) begin
                  pace = regs_in[0][6:4];
                  slope = regs_in[0][2:0];
                  sweep_in = sweep_ff + 8'd1;
                  if (sweep_in >= {5'd0, pace}) begin
                     sweep_in = '0;
                     if (pace != '0) begin
                        sp = {regs_in[4][2:0], regs_in[3]};
                        sd = sp >> slope;
                        sn = regs_in[0][3] ? {1'b0, sp} - {1'b0, sd} : {1'b0, sp} + {1'b0, sd};
                        if (sn > 12'h7ff) on_in[0] = 1'b0;
                        else if (slope != '0) begin
                           regs_in[3] = sn[7:0];
                           regs_in[4] = {regs_in[4][7:3], sn[10:8]};
                        end
                     end
                  end
               end
               if (frame_in[2:0] == 3'd0) begin
                  for (int e = 0; e < 3; e++) begin
                     er = (e == 0) ? 2 : (e == 1) ? 7 : 17;
                     epace = regs_in[er][2:0];
                     vol = regs_in[er][7:4];
                     if (epace != '0) begin
                        env_in[e] = env_ff[e] + 8'd1;
                        if (env_in[e] >= {5'd0, epace}) begin
                           env_in[e] = '0;
                           if (regs_in[er][3]) begin
                              if (vol < 4'd15) vol = vol + 4'd1;
                           end else if (vol != '0) vol = vol - 4'd1;
                           regs_in[er] = {vol, regs_in[er][3:0]};
                        end
                     end
                  end
               end
            end
         end
      end
   end

   // Mixing from the post-tick state.
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         c[k] = '0;
      end
      c[2] = '0; c[3] = '0;
      ws = pos_in[2][4:0];
      wb = wave_in[ws[4:1]];
      wv = $signed({2'b00, ws[0] ? wb[3:0] : wb[7:4]}) - 6'sd8;
      case (regs_in[12][6:5])
         2'd0: wv = '0;
         2'd2: wv = wv / 2;
         2'd3: wv = wv / 4;
         default: wv = wv;
      endcase
      ps = '0; pv = '0; hi = 1'b0;
      if (regs_in[22][7]) begin
         for (int k = 0; k < 2; k++) begin
            ps = pos_in[k][2:0];
            case (regs_in[k == 0 ? 1 : 6][7:6])
               2'd0: hi = (ps != '0);
               2'd2: hi = (ps < 3'd4);
               default: hi = (ps < 3'd2);
            endcase
            pv = hi ? 7'sd32 : -7'sd32;
            if (on_in[k]) c[k] = 10'(pv * $signed({1'b0, regs_in[k == 0 ? 2 : 7][7:4]}));
         end
         if (on_in[2]) c[2] = 10'(wv * 7'sd32);
         if (on_in[3]) begin
            pv = (pos_in[3] != '0) ? 7'sd32 : -7'sd32;
            c[3] = 10'(pv * $signed({1'b0, regs_in[17][7:4]}));
         end
      end
      lsum = '0; rsum = '0;
      for (int k = 0; k < 4; k++) begin
         if (regs_in[21][k+4]) lsum = lsum + 12'(c[k]);
         if (regs_in[21][k]) rsum = rsum + 12'(c[k]);
      end
      lmix = 16'(lsum * $signed({2'b00, regs_in[20][6:4]} + 5'sd1));
      rmix = 16'(rsum * $signed({2'b00, regs_in[20][2:0]} + 5'sd1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 23; i++) regs_ff[i] <= '0;
         for (int i = 0; i < 16; i++) wave_ff[i] <= '0;
         for (int i = 0; i < 4; i++) begin
            per_ff[i] <= '0; pos_ff[i] <= '0;
         end
         for (int i = 0; i < 3; i++) env_ff[i] <= '0;
         on_ff <= '0; pend_ff <= '0; dac_ff <= '0;
         sweep_ff <= '0; frame_ff <= '0; lastdiv_ff <= '0;
         lfsr_ff <= 15'h7fff; pre_ff <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            regs_ff <= regs_in; wave_ff <= wave_in; on_ff <= on_in; pend_ff <= pend_in;
            dac_ff <= dac_in; per_ff <= per_in; pos_ff <= pos_in; env_ff <= env_in;
            sweep_ff <= sweep_in; frame_ff <= frame_in; lfsr_ff <= lfsr_in; pre_ff <= pre_in;
            if (!op.is_write && power) lastdiv_ff <= op.div_value;
         end
         if (fire && op.emit) res_valid_ff <= 1'b1;
         else if (res_ready) res_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && op.emit) begin
         res_ff.left_sample <= lmix[14:0];
         res_ff.right_sample <= rmix[14:0];
         res_ff.active_channels <= on_in;
      end
   end

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// Four-channel sound unit testbench
// Drives tick and register / wave RAM write words into the unit and predicts
// every mixed stereo sample with a cycle-free behavioral model of the four
// channels, frame sequencer and mixer. Results are compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import fcsu_pkg::*;

   localparam int LevelPulse = 32;
   localparam int WatchdogLimit = 20000;
   localparam logic ModeTick = 1'b0;
   localparam logic ModeWrite = 1'b1;
   localparam logic [5:0] AddrNr10 = 6'd0, AddrNr11 = 6'd1, AddrNr12 = 6'd2,
      AddrNr13 = 6'd3, AddrNr14 = 6'd4, AddrNr21 = 6'd6, AddrNr22 = 6'd7,
      AddrNr23 = 6'd8, AddrNr24 = 6'd9, AddrNr30 = 6'd10, AddrNr31 = 6'd11,
      AddrNr32 = 6'd12, AddrNr33 = 6'd13, AddrNr34 = 6'd14, AddrNr41 = 6'd16,
      AddrNr42 = 6'd17, AddrNr43 = 6'd18, AddrNr44 = 6'd19, AddrNr50 = 6'd20,
      AddrNr51 = 6'd21, AddrWave = 6'd32;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tuser = '0;    // [0] mode
   logic [23:0] req_tdata = '0;   // [5:0] reg_addr, [13:6] reg_data, [21:14] div_value
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // [14:0] left, [29:15] right, [33:30] active

   four_channel_sound_unit_top dut (.*);

   always #10 clock = ~clock;

   // Predictor state.
   logic [7:0] regs [23];
   logic [7:0] wave [16];
   logic [3:0] ch_on, trig_pend;
   logic [2:0] dac;
   logic [15:0] per_cnt [4];
   logic [7:0] step_pos [4];
   logic [7:0] env_cnt [3];
   logic [7:0] sweep_cnt, frame_cnt, div_last, tick_cnt;
   logic [14:0] lfsr;
   logic [1:0] noise_pre;
   logic [7:0] div_now = '0;

   result_type samples_due [$];
   int errors = 0;
   int idle_cycles = 0;
   bit rx_random = 1'b0;
   bit tx_random = 1'b0;
   int rx_hold = 0;

   function automatic logic [15:0] period(int lo, int hi);
      return {5'd0, regs[hi][2:0], regs[lo]};
   endfunction

   function automatic void envelope(int r, int idx);
      logic [3:0] vol;
      vol = regs[r][7:4];
      if (regs[r][2:0] == 0) return;
      env_cnt[idx]++;
      if (env_cnt[idx] >= regs[r][2:0]) begin
         env_cnt[idx] = 0;
         if (regs[r][3]) begin
            if (vol < 15) vol++;
         end else if (vol != 0) vol--;
         regs[r][7:4] = vol;
      end
   endfunction

   function automatic void length_step(int lr, int cr, logic [7:0] mask, int ch);
      logic [7:0] len;
      if (!regs[cr][6] || !ch_on[ch]) return;
      len = (regs[lr] + 8'd1) & mask;
      regs[lr] = (regs[lr] & ~mask) | len;
      if (len == 0) ch_on[ch] = 1'b0;
   endfunction

   function automatic void frame_advance();
      logic [15:0] p, d, n;
      logic [2:0] pace, slope;
      frame_cnt++;
      if (!frame_cnt[0]) begin
         length_step(1, 4, 8'h3f, 0);
         length_step(6, 9, 8'h3f, 1);
         length_step(11, 14, 8'hff, 2);
         length_step(16, 19, 8'h3f, 3);
      end
      if (frame_cnt[1:0] == 0) begin
         pace = regs[0][6:4];
         slope = regs[0][2:0];
         sweep_cnt++;
         if (sweep_cnt >= pace) begin
            sweep_cnt = 0;
            if (pace != 0) begin
               p = period(3, 4);
               d = p >> slope;
               n = regs[0][3] ? p - d : p + d;
               if (n > 16'h7ff) ch_on[0] = 1'b0;
               else if (slope != 0) begin
                  regs[3] = n[7:0];
                  regs[4][2:0] = n[10:8];
               end
            end
         end
      end
      if (frame_cnt[2:0] == 0) begin
         envelope(2, 0);
         envelope(7, 1);
         envelope(17, 2);
      end
   endfunction

   function automatic void channels_tick(logic [7:0] dv);
      logic [7:0] r;
      logic [31:0] lim;
      logic fb;
      if (trig_pend[0] && dac[0]) begin
         trig_pend[0] = 0; ch_on[0] = 1; per_cnt[0] = period(3, 4);
      end
      if (trig_pend[1] && dac[1]) begin
         trig_pend[1] = 0; ch_on[1] = 1; per_cnt[1] = period(8, 9);
      end
      if (trig_pend[2] && regs[10][7]) begin
         trig_pend[2] = 0; ch_on[2] = 1; step_pos[2] = 0; per_cnt[2] = period(13, 14);
      end
      if (trig_pend[3] && dac[2]) begin
         trig_pend[3] = 0; ch_on[3] = 1; step_pos[3] = 0; per_cnt[3] = 0;
         lfsr = 15'h7fff;
      end
      for (int c = 0; c < 2; c++)
         if (ch_on[c]) begin
            per_cnt[c]++;
            if (per_cnt[c] >= 2048) begin
               per_cnt[c] = c == 0 ? period(3, 4) : period(8, 9);
               step_pos[c]++;
            end
         end
      if (ch_on[2]) begin
         per_cnt[2] += 2;
         if (per_cnt[2] >= 2048) begin
            per_cnt[2] = per_cnt[2] - 2048 + period(13, 14);
            step_pos[2] = (step_pos[2] + 1) & 8'h1f;
         end
      end
      if (ch_on[3] && noise_pre == 0) begin
         r = regs[18];
         lim = 32'd1 << r[7:4];
         if (r[2:0] != 0) lim = lim * r[2:0];
         else lim = lim >> 1;
         lim &= 32'hffff;
         per_cnt[3]++;
         if (per_cnt[3] >= lim) begin
            fb = lfsr[0] ^ lfsr[1];
            per_cnt[3] = 0;
            lfsr = {fb, lfsr[14:1]};
            if (r[3]) lfsr[6] = fb;
            step_pos[3] = {7'd0, ~lfsr[0]};
         end
      end
      if (div_last[4] && !dv[4]) frame_advance();
      div_last = dv;
   endfunction

   function automatic int pulse_level(int ch, int dr, int vr);
      logic [2:0] s;
      int v;
      s = step_pos[ch][2:0];
      case (regs[dr][7:6])
         2'd0: v = s != 0 ? LevelPulse : -LevelPulse;
         2'd2: v = s < 4 ? LevelPulse : -LevelPulse;
         default: v = s < 2 ? LevelPulse : -LevelPulse;
      endcase
      return v * int'(regs[vr][7:4]);
   endfunction

   function automatic int wave_level();
      logic [4:0] s;
      int v;
      s = step_pos[2][4:0];
      v = int'(s[0] ? wave[s[4:1]][3:0] : wave[s[4:1]][7:4]) - 8;
      case (regs[12][6:5])
         2'd0: v = 0;
         2'd2: v = v / 2;
         2'd3: v = v / 4;
         default: ;
      endcase
      return v * LevelPulse;
   endfunction

   function automatic void register_write(logic [5:0] a, logic [7:0] d);
      if (a >= 32 && a < 48) begin
         wave[a - 32] = d;
         return;
      end
      if (a == AddrNr52) begin
         if (!d[7] && regs[22][7]) begin
            for (int i = 0; i < 22; i++) regs[i] = 0;
            ch_on = 0; trig_pend = 0; dac = 0;
         end
         regs[22] = d & 8'h80;
         return;
      end
      if (a > 21 || a == 5 || a == 15 || !regs[22][7]) return;
      if (a == AddrNr14 || a == AddrNr24 || a == AddrNr34 || a == AddrNr44) begin
         regs[a] = d & 8'h7f;
         if (d[7])
            trig_pend[a == AddrNr14 ? 0 : a == AddrNr24 ? 1 : a == AddrNr34 ? 2 : 3] = 1'b1;
         return;
      end
      regs[a] = d;
      if (a == AddrNr12 || a == AddrNr22 || a == AddrNr42) begin
         if (d[7:3] != 0) dac[a == AddrNr12 ? 0 : a == AddrNr22 ? 1 : 2] = 1'b1;
         else begin
            dac[a == AddrNr12 ? 0 : a == AddrNr22 ? 1 : 2] = 1'b0;
            ch_on[a == AddrNr12 ? 0 : a == AddrNr22 ? 1 : 3] = 1'b0;
         end
      end
      if (a == AddrNr30 && !d[7]) ch_on[2] = 1'b0;
   endfunction

   // Advances the model by one word and queues the sample it produces, if any.
   function automatic void predict_word(logic mode, logic [5:0] a, logic [7:0] d,
                                        logic [7:0] dv);
      int c [4];
      int l, r;
      result_type res;
      if (mode == ModeWrite) begin
         register_write(a, d);
         return;
      end
      tick_cnt = 8'((tick_cnt + 1) % TICKS_PER_SAMPLE);
      noise_pre++;
      if (regs[22][7]) channels_tick(dv);
      if (tick_cnt != 0) return;
      c = '{0, 0, 0, 0};
      if (regs[22][7]) begin
         if (ch_on[0]) c[0] = pulse_level(0, 1, 2);
         if (ch_on[1]) c[1] = pulse_level(1, 6, 7);
         if (ch_on[2]) c[2] = wave_level();
         if (ch_on[3]) c[3] = (step_pos[3] != 0 ? LevelPulse : -LevelPulse)
                              * int'(regs[17][7:4]);
      end
      l = 0; r = 0;
      for (int k = 0; k < 4; k++) begin
         if (regs[21][k + 4]) l += c[k];
         if (regs[21][k]) r += c[k];
      end
      l *= int'(regs[20][6:4]) + 1;
      r *= int'(regs[20][2:0]) + 1;
      res.left_sample = l[14:0];
      res.right_sample = r[14:0];
      res.active_channels = ch_on;
      samples_due.push_back(res);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // The valid line stays high from one word to the next and drops only for
   // an idle burst or when the sender waits for the results.
   task automatic send_word(logic mode, logic [5:0] a, logic [7:0] d, logic [7:0] dv);
      if (tx_random && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= {7'd0, mode};
      req_tdata <= {2'd0, dv, d, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_word(mode, a, d, dv);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [5:0] a, logic [7:0] d);
      send_word(ModeWrite, a, d, 8'h00);
   endtask

   // The divider advances so that bit 4 falls regularly and drives the frame steps.
   task automatic tick(int n);
      repeat (n) begin
         div_now += 8'd3;
         send_word(ModeTick, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                   div_now);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (samples_due.size() != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.left_sample = rsp_tdata[14:0];
         got.right_sample = rsp_tdata[29:15];
         got.active_channels = rsp_tdata[33:30];
         if (samples_due.size() == 0) report_mismatch("unexpected sample", 0, 0);
         else begin
            want = samples_due.pop_front();
            if (got.left_sample !== want.left_sample)
               report_mismatch("left", got.left_sample, want.left_sample);
            if (got.right_sample !== want.right_sample)
               report_mismatch("right", got.right_sample, want.right_sample);
            if (got.active_channels !== want.active_channels)
               report_mismatch("active", got.active_channels, want.active_channels);
         end
      end
   end

   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rsp_tready <= 1'b0;
         rx_hold--;
      end else if (rx_random && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         rx_hold = $urandom_range(1, 16) - 1;
      end else rsp_tready <= 1'b1;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic test_power_and_extremes();
      write_reg(AddrNr52, 8'h80);
      write_reg(AddrNr50, 8'h77);
      write_reg(AddrNr51, 8'hff);
      write_reg(AddrNr12, 8'hf0);
      write_reg(AddrNr11, 8'h80);
      write_reg(AddrNr13, 8'hff);
      write_reg(AddrNr14, 8'hc7);
      write_reg(AddrNr22, 8'hf8);
      write_reg(AddrNr21, 8'hff);
      write_reg(AddrNr24, 8'h87);
      write_reg(AddrNr30, 8'h80);
      write_reg(AddrNr32, 8'h20);
      write_reg(AddrWave, 8'hf0);
      write_reg(AddrWave + 6'd15, 8'h0f);
      write_reg(AddrNr34, 8'hc7);
      write_reg(AddrNr42, 8'hff);
      write_reg(AddrNr43, 8'h08);
      write_reg(AddrNr44, 8'hc0);
      write_reg(6'd5, 8'hff);
      write_reg(6'd15, 8'hff);
      write_reg(6'd63, 8'hff);
      tick(64);
      write_reg(AddrNr30, 8'h00);
      write_reg(AddrNr42, 8'h00);
      tick(32);
      write_reg(AddrNr52, 8'h00);
      write_reg(AddrNr11, 8'hff);
      tick(32);
      drain();
   endtask

   task automatic test_sweep_and_envelope();
      write_reg(AddrNr52, 8'h80);
      write_reg(AddrNr50, 8'h70);
      write_reg(AddrNr51, 8'h11);
      write_reg(AddrNr10, 8'h11);
      write_reg(AddrNr12, 8'h19);
      write_reg(AddrNr13, 8'h00);
      write_reg(AddrNr14, 8'h84);
      tick(200);
      write_reg(AddrNr10, 8'h7f);
      write_reg(AddrNr14, 8'h87);
      write_reg(AddrNr42, 8'h81);
      write_reg(AddrNr43, 8'h00);
      write_reg(AddrNr44, 8'h80);
      tick(200);
      drain();
   endtask

   task automatic random_word();
      int k;
      k = $urandom_range(0, 9);
      if (k < 6) tick($urandom_range(1, 20));
      else if (k < 8) write_reg(6'($urandom_range(0, 22)), 8'($urandom));
      else if (k < 9) write_reg(6'($urandom_range(32, 47)), 8'($urandom));
      else write_reg(AddrNr52, {$urandom_range(0, 7) != 0, 7'($urandom)});
   endtask

   task automatic test_random_traffic();
      tx_random = 1'b1;
      rx_random = 1'b1;
      write_reg(AddrNr52, 8'h80);
      repeat (55) random_word();
      drain();
   endtask

   task automatic test_back_pressure();
      rx_hold = 400;
      tick(60);
      tx_random = 1'b0;
      rx_random = 1'b0;
      repeat (12) random_word();
      drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 23; i++) regs[i] = 0;
      for (int i = 0; i < 16; i++) wave[i] = 0;
      for (int i = 0; i < 4; i++) begin
         per_cnt[i] = 0; step_pos[i] = 0;
      end
      for (int i = 0; i < 3; i++) env_cnt[i] = 0;
      ch_on = 0; trig_pend = 0; dac = 0;
      sweep_cnt = 0; frame_cnt = 0; div_last = 0; tick_cnt = 0;
      lfsr = 15'h7fff; noise_pre = 0;
      test_power_and_extremes();
      test_sweep_and_envelope();
      test_random_traffic();
      test_back_pressure();
      drain();
      repeat (20) @(posedge clock);
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule

[filelist.f]
rtl/core/fcsu_pkg.sv
rtl/core/fcsu_front.sv
rtl/core/fcsu_back.sv
rtl/core/four_channel_sound_unit_top.sv
verif/tb_top.sv
